// ----- sv/stt_pkg.sv -----
// shared types and constants for the transposition table
`timescale 1ns / 1ps

package stt_pkg;

   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 8;
   localparam int BOUND_W = 2;
   localparam int SCORE_W = 20;
   localparam int PLY_W   = 8;
   localparam int MOVE_W  = 16;

   // mate range limits
   localparam logic signed [SCORE_W-1:0] MATE_LOW      = 20'sd99000;
   localparam logic signed [SCORE_W-1:0] MATE_HIGH     = 20'sd100000;
   localparam logic signed [SCORE_W-1:0] NEG_MATE_LOW  = -20'sd99000;
   localparam logic signed [SCORE_W-1:0] NEG_MATE_HIGH = -20'sd100000;

   localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
   localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
   localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

   localparam logic [MOVE_W-1:0] NULL_MOVE = '0;

   typedef enum logic [1:0] {
      MODE_PROBE = 2'd0,
      MODE_STORE = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      mode_type                    mode;
      logic [KEY_W-1:0]            position_key;
      logic [DEPTH_W-1:0]          search_depth;
      logic signed [SCORE_W-1:0]   node_score;
      logic [BOUND_W-1:0]          bound_kind;
      logic [PLY_W-1:0]            ply_from_root;
      logic [MOVE_W-1:0]           best_move_in;
      logic signed [SCORE_W-1:0]   window_low;
      logic signed [SCORE_W-1:0]   window_high;
   } req_payload_type;

   typedef struct packed {
      logic                        key_match;
      logic                        cutoff_valid;
      logic signed [SCORE_W-1:0]   cutoff_score;
      logic [MOVE_W-1:0]           stored_move;
      logic                        op_done;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;    // input transfer: latch item, read entry
      logic sweep;      // write zeros at the sweep counter
      logic sweep_all;  // sweep also zeroes depth, bound and score
      logic finish;     // write back a store and load the result
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic out_free;
   } status_type;

endpackage

// ----- sv/stt_if.sv -----
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps

interface stt_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [63:0]         position_key;
   logic [7:0]          search_depth;
   logic signed [19:0]  node_score;
   logic [1:0]          bound_kind;
   logic [7:0]          ply_from_root;
   logic [15:0]         best_move_in;
   logic signed [19:0]  window_low;
   logic signed [19:0]  window_high;

   modport source (
      output valid, mode, position_key, search_depth, node_score, bound_kind,
             ply_from_root, best_move_in, window_low, window_high,
      input  ready
   );
   modport sink (
      input  valid, mode, position_key, search_depth, node_score, bound_kind,
             ply_from_root, best_move_in, window_low, window_high,
      output ready
   );
endinterface

interface stt_rsp_if;
   logic                valid;
   logic                ready;
   logic                key_match;
   logic                cutoff_valid;
   logic signed [19:0]  cutoff_score;
   logic [15:0]         stored_move;
   logic                op_done;

   modport source (
      output valid, key_match, cutoff_valid, cutoff_score, stored_move, op_done,
      input  ready
   );
   modport sink (
      input  valid, key_match, cutoff_valid, cutoff_score, stored_move, op_done,
      output ready
   );
endinterface

// ----- sv/stt_ctrl.sv -----
// sequencing of reset sweep, probe/store, clear and result hand-off
`timescale 1ns / 1ps

module stt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  stt_pkg::mode_type     req_mode,
   input  stt_pkg::status_type   status,
   output logic                  req_ready,
   output stt_pkg::cmd_type      cmd
);

   stt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stt_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stt_pkg::ST_INIT: begin
            if (status.sweep_last) state_in = stt_pkg::ST_IDLE;
         end
         stt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == stt_pkg::MODE_CLEAR) state_in = stt_pkg::ST_CLEAR;
               else state_in = stt_pkg::ST_EXEC;
            end
         end
         stt_pkg::ST_CLEAR: begin
            if (status.sweep_last) state_in = stt_pkg::ST_EXEC;
         end
         stt_pkg::ST_EXEC: begin
            if (status.out_free) state_in = stt_pkg::ST_IDLE;
         end
         default: begin
            state_in = stt_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         stt_pkg::ST_INIT: begin
            cmd.sweep     = 1'b1;
            cmd.sweep_all = 1'b1;
         end
         stt_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         stt_pkg::ST_CLEAR: begin
            cmd.sweep = 1'b1;
         end
         stt_pkg::ST_EXEC: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/stt_datapath.sv -----
// entry memories, sweep counter, probe evaluation and result register
`timescale 1ns / 1ps

module stt_datapath #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stt_pkg::req_payload_type req_data,
   input  stt_pkg::cmd_type         cmd,
   output stt_pkg::status_type      status,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output stt_pkg::rsp_payload_type rsp_data
);

   // entry index is the low key bits, so the user must keep the depth a power of two; nothing here enforces it
   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   typedef struct packed {
      logic [stt_pkg::KEY_W-1:0]  key;
      logic [stt_pkg::MOVE_W-1:0] move;
   } km_entry_type;

   typedef struct packed {
      logic [stt_pkg::DEPTH_W-1:0]        depth;
      logic [stt_pkg::BOUND_W-1:0]        bound;
      logic signed [stt_pkg::SCORE_W-1:0] score;
   } dbs_entry_type;

   km_entry_type  km_mem  [TABLE_ENTRIES];
   dbs_entry_type dbs_mem [TABLE_ENTRIES];

   km_entry_type              km_rd_ff;
   dbs_entry_type             dbs_rd_ff;
   stt_pkg::req_payload_type  item_ff;
   logic [IDX_W-1:0]          sweep_cnt_ff;
   logic                      rsp_valid_ff;
   stt_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]                   item_idx;
   logic                               store_we;
   logic                               km_we, dbs_we;
   logic [IDX_W-1:0]                   km_addr;
   km_entry_type                       km_wdata;
   dbs_entry_type                      dbs_wdata;
   logic signed [stt_pkg::SCORE_W-1:0] ply_s;
   logic signed [stt_pkg::SCORE_W-1:0] in_score, tbl_score, rd_score, adj_score;
   logic signed [stt_pkg::SCORE_W-1:0] alpha, beta;
   logic                               match, depth_ok, cut;

   assign item_idx = item_ff.position_key[IDX_W-1:0];
   assign ply_s    = $signed({{(stt_pkg::SCORE_W-stt_pkg::PLY_W){1'b0}},
                              item_ff.ply_from_root});
   assign in_score = item_ff.node_score;
   assign alpha    = item_ff.window_low;
   assign beta     = item_ff.window_high;
   assign rd_score = dbs_rd_ff.score;

   // ply independent score on the way in
   always_comb begin
      if (in_score > stt_pkg::MATE_LOW && in_score <= stt_pkg::MATE_HIGH) begin
         tbl_score = in_score + ply_s;
      end else if (in_score < stt_pkg::NEG_MATE_LOW &&
                   in_score >= stt_pkg::NEG_MATE_HIGH) begin
         tbl_score = in_score - ply_s;
      end else begin
         tbl_score = in_score;
      end
   end

   // and back relative to the probing node
   always_comb begin
      if (rd_score > stt_pkg::MATE_LOW) begin
         adj_score = rd_score - ply_s;
      end else if (rd_score < stt_pkg::NEG_MATE_LOW) begin
         adj_score = rd_score + ply_s;
      end else begin
         adj_score = rd_score;
      end
   end

   assign match    = (km_rd_ff.key == item_ff.position_key);
   assign depth_ok = (dbs_rd_ff.depth >= item_ff.search_depth);

   always_comb begin
      cut = 1'b0;
      case (dbs_rd_ff.bound)
         stt_pkg::BOUND_EXACT: cut = 1'b1;
         stt_pkg::BOUND_UPPER: cut = (adj_score <= alpha);
         stt_pkg::BOUND_LOWER: cut = (adj_score >= beta);
         default:              cut = 1'b0;
      endcase
      cut = cut && match && depth_ok;
   end

   always_comb begin
      rsp_data_in = '0;
      case (item_ff.mode)
         stt_pkg::MODE_PROBE: begin
            rsp_data_in.key_match    = match;
            rsp_data_in.cutoff_valid = cut;
            rsp_data_in.cutoff_score = cut ? adj_score : '0;
            rsp_data_in.stored_move  = km_rd_ff.move;
         end
         stt_pkg::MODE_STORE,
         stt_pkg::MODE_CLEAR: begin
            rsp_data_in.op_done = 1'b1;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   // null move store leaves the entry alone
   assign store_we = cmd.finish && item_ff.mode == stt_pkg::MODE_STORE &&
                     item_ff.best_move_in != stt_pkg::NULL_MOVE;

   assign km_we     = cmd.sweep || store_we;
   assign dbs_we    = (cmd.sweep && cmd.sweep_all) || store_we;
   assign km_addr   = cmd.sweep ? sweep_cnt_ff : item_idx;
   assign km_wdata  = cmd.sweep ? km_entry_type'('0)
                                : km_entry_type'{key:  item_ff.position_key,
                                                 move: item_ff.best_move_in};
   assign dbs_wdata = cmd.sweep ? dbs_entry_type'('0)
                                : dbs_entry_type'{depth: item_ff.search_depth,
                                                  bound: item_ff.bound_kind,
                                                  score: tbl_score};

   always_ff @(posedge clock) begin
      if (km_we) km_mem[km_addr] <= km_wdata;
      if (dbs_we) dbs_mem[km_addr] <= dbs_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff   <= req_data;
         km_rd_ff  <= km_mem[req_data.position_key[IDX_W-1:0]];
         dbs_rd_ff <= dbs_mem[req_data.position_key[IDX_W-1:0]];
      end
   end

   // counter wraps to zero at the end of every sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_data_ff <= rsp_data_in;
   end

   assign status.sweep_last = &sweep_cnt_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

endmodule

// ----- sv/search_transposition_table.sv -----
// top level of the direct-mapped transposition table
//
//   channel   dir   handshake              carries
//   req_ch    in    valid/ready (sink)     mode, key, depth, score, bound, ply, move, window
//   rsp_ch    out   valid/ready (source)   key_match, cutoff, score, stored_move, op_done
//
// probe and store, one item at a time: item latched and entry read through the registered
// memory port at the input transfer, then compare or write; the result goes to the output
// register once it is free; clear: key and move of one entry zeroed per cycle, depth, bound
// and score kept; after reset a clearing pass over every entry holds req_ch.ready low
// a result waits in the output register; the next item is taken meanwhile and
// held until that register is free
`timescale 1ns / 1ps

module search_transposition_table #(
   parameter int TABLE_ENTRIES = 4096
) (
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req_ch,
   stt_rsp_if.source rsp_ch
);

   stt_pkg::req_payload_type req_data;
   stt_pkg::rsp_payload_type rsp_data;
   stt_pkg::cmd_type         cmd;
   stt_pkg::status_type      status;
   stt_pkg::mode_type        req_mode;

   assign req_mode = stt_pkg::mode_type'(req_ch.mode);

   assign req_data = '{
      mode:          req_mode,
      position_key:  req_ch.position_key,
      search_depth:  req_ch.search_depth,
      node_score:    req_ch.node_score,
      bound_kind:    req_ch.bound_kind,
      ply_from_root: req_ch.ply_from_root,
      best_move_in:  req_ch.best_move_in,
      window_low:    req_ch.window_low,
      window_high:   req_ch.window_high
   };

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   stt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_ch.key_match    = rsp_data.key_match;
   assign rsp_ch.cutoff_valid = rsp_data.cutoff_valid;
   assign rsp_ch.cutoff_score = rsp_data.cutoff_score;
   assign rsp_ch.stored_move  = rsp_data.stored_move;
   assign rsp_ch.op_done      = rsp_data.op_done;

endmodule

// ----- sv/stt_checker.sv -----
// port-level assertions for the transposition table, bound to the top level
`timescale 1ns / 1ps

module stt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_key_match,
   input logic        rsp_cutoff_valid,
   input logic [19:0] rsp_cutoff_score,
   input logic [15:0] rsp_stored_move,
   input logic        rsp_op_done
);

   // a pending result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_key_match) && $stable(rsp_cutoff_valid) &&
         $stable(rsp_cutoff_score) && $stable(rsp_stored_move) &&
         $stable(rsp_op_done))
      else $error("response payload changed while stalled");

   // one item in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer taken back to back");

   // a cutoff needs a key hit, and no cutoff means a zero score
   a_cutoff_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_cutoff_valid || rsp_key_match) &&
                    (rsp_cutoff_valid || rsp_cutoff_score == 20'd0))
      else $error("inconsistent cutoff fields");

   // store and clear results carry nothing else
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op_done |-> !rsp_key_match && !rsp_cutoff_valid &&
                                   rsp_cutoff_score == 20'd0 &&
                                   rsp_stored_move == 16'd0)
      else $error("store or clear result carries probe fields");

endmodule

bind search_transposition_table stt_checker u_stt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_key_match    (rsp_ch.key_match),
   .rsp_cutoff_valid (rsp_ch.cutoff_valid),
   .rsp_cutoff_score (rsp_ch.cutoff_score),
   .rsp_stored_move  (rsp_ch.stored_move),
   .rsp_op_done      (rsp_ch.op_done)
);

// ----- test/tb_search_transposition_table.sv -----
// self-checking testbench for the transposition table: directed rows, then random traffic
`timescale 1ns / 1ps

module tb_search_transposition_table;

   localparam int ENTRIES      = 4096;
   localparam int RANDOM_ITEMS = 1400;
   localparam int DRAIN_AT     = 700;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;

   localparam stt_pkg::rsp_payload_type RSP_DONE      = '{1'b0, 1'b0, 20'sd0, 16'd0, 1'b1};
   localparam stt_pkg::rsp_payload_type RSP_NONE      = '{1'b0, 1'b0, 20'sd0, 16'd0, 1'b0};
   localparam stt_pkg::rsp_payload_type RSP_EMPTY_HIT = '{1'b1, 1'b1, 20'sd0, 16'd0, 1'b0};

   localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      stt_pkg::req_payload_type item;
      bit                       typed;
      stt_pkg::rsp_payload_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   search_transposition_table #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the table
   logic [63:0] shadow_key   [ENTRIES];
   logic [7:0]  shadow_depth [ENTRIES];
   logic [1:0]  shadow_bound [ENTRIES];
   logic [15:0] shadow_move  [ENTRIES];
   int          shadow_score [ENTRIES];

   stt_pkg::rsp_payload_type expected_rsp_q[$];
   table_row_type            directed_rows[$];

   int  errors         = 0;
   int  items_accepted = 0;
   int  clears_left    = 8;
   int  burst_left     = 1;
   int  pending_gap    = 0;
   bit  no_idle        = 1'b0;

   logic [51:0] key_tags  [4];
   logic [11:0] key_slots [12];

   function automatic int sx20(logic [19:0] v);
      int r;
      r = {{12{v[19]}}, v};
      return r;
   endfunction

   function automatic stt_pkg::rsp_payload_type predict_table_op(
         stt_pkg::req_payload_type r);
      stt_pkg::rsp_payload_type res;
      int unsigned              idx;
      int                       s;
      int                       ply;
      bit                       cut;
      res = RSP_NONE;
      idx = int'(r.position_key % 64'(ENTRIES));
      ply = int'(r.ply_from_root);
      cut = 1'b0;
      case (r.mode)
         stt_pkg::MODE_PROBE: begin
            s = shadow_score[idx];
            if (s > int'(stt_pkg::MATE_LOW))
               s = s - ply;
            else if (s < int'(stt_pkg::NEG_MATE_LOW))
               s = s + ply;
            res.key_match = (shadow_key[idx] == r.position_key);
            if (res.key_match && shadow_depth[idx] >= r.search_depth) begin
               case (shadow_bound[idx])
                  stt_pkg::BOUND_EXACT: cut = 1'b1;
                  stt_pkg::BOUND_UPPER: cut = (s <= sx20(r.window_low));
                  stt_pkg::BOUND_LOWER: cut = (s >= sx20(r.window_high));
                  default:              cut = 1'b0;
               endcase
            end
            res.cutoff_valid = cut;
            res.cutoff_score = cut ? s[19:0] : '0;
            res.stored_move  = shadow_move[idx];
         end
         stt_pkg::MODE_STORE: begin
            if (r.best_move_in != stt_pkg::NULL_MOVE) begin
               s = sx20(r.node_score);
               // mate scores are kept relative to the node, not the root
               if (s > int'(stt_pkg::MATE_LOW) && s <= int'(stt_pkg::MATE_HIGH))
                  s = s + ply;
               else if (s < int'(stt_pkg::NEG_MATE_LOW) &&
                        s >= int'(stt_pkg::NEG_MATE_HIGH))
                  s = s - ply;
               shadow_key[idx]   = r.position_key;
               shadow_depth[idx] = r.search_depth;
               shadow_bound[idx] = r.bound_kind;
               shadow_move[idx]  = r.best_move_in;
               shadow_score[idx] = s;
            end
            res.op_done = 1'b1;
         end
         stt_pkg::MODE_CLEAR: begin
            // depth, bound and score survive a clear
            for (int i = 0; i < ENTRIES; i++) begin
               shadow_key[i]  = '0;
               shadow_move[i] = '0;
            end
            res.op_done = 1'b1;
         end
         default: res = RSP_NONE;
      endcase
      return res;
   endfunction

   function automatic stt_pkg::req_payload_type req_of(stt_pkg::mode_type m,
                                                       logic [63:0] k, int d, int sc,
                                                       logic [1:0] b, int p, int mv,
                                                       int lo, int hi);
      stt_pkg::req_payload_type r;
      r.mode          = m;
      r.position_key  = k;
      r.search_depth  = d[7:0];
      r.node_score    = sc[19:0];
      r.bound_kind    = b;
      r.ply_from_root = p[7:0];
      r.best_move_in  = mv[15:0];
      r.window_low    = lo[19:0];
      r.window_high   = hi[19:0];
      return r;
   endfunction

   task automatic add_row(input stt_pkg::req_payload_type item, input bit typed = 1'b0,
                          input stt_pkg::rsp_payload_type want = '0);
      directed_rows.push_back('{item, typed, want});
   endtask

   function automatic stt_pkg::req_payload_type random_item();
      stt_pkg::req_payload_type r;
      int                       pick;
      int                       sc;
      pick = $urandom_range(0, 999);
      if (pick < 5 && clears_left > 0) begin
         r.mode = stt_pkg::MODE_CLEAR;
         clears_left--;
      end else if (pick < 35)
         r.mode = stt_pkg::MODE_NOP;
      else if (pick < 480)
         r.mode = stt_pkg::MODE_STORE;
      else
         r.mode = stt_pkg::MODE_PROBE;
      // mostly a small pool of keys so that probes find stored entries
      if ($urandom_range(0, 9) == 0)
         r.position_key = {$urandom, $urandom};
      else
         r.position_key = {key_tags[$urandom_range(0, 3)], key_slots[$urandom_range(0, 11)]};
      case ($urandom_range(0, 9))
         0, 1:    sc = $urandom_range(98995, 100005);
         2, 3:    sc = -int'($urandom_range(98995, 100005));
         4:       sc = $urandom_range(0, 1) ? 524287 : -524288;
         default: sc = $urandom;
      endcase
      r.node_score    = sc[19:0];
      r.search_depth  = 8'($urandom);
      r.bound_kind    = 2'($urandom);
      r.ply_from_root = 8'($urandom);
      r.best_move_in  = ($urandom_range(0, 7) == 0) ? stt_pkg::NULL_MOVE : 16'($urandom);
      r.window_low    = ($urandom_range(0, 3) == 0) ?
                        20'(sc + int'($urandom_range(0, 600)) - 300) : 20'($urandom);
      r.window_high   = ($urandom_range(0, 3) == 0) ?
                        20'(sc + int'($urandom_range(0, 600)) - 300) : 20'($urandom);
      return r;
   endfunction

   // one request transfer; the gap chosen at the end of a burst is spent first unless no_idle is set
   task automatic offer(input stt_pkg::req_payload_type item, input bit typed,
                        input stt_pkg::rsp_payload_type want);
      stt_pkg::rsp_payload_type pred;
      if (pending_gap > 0 && !no_idle) begin
         req_ch.valid <= 1'b0;
         repeat (pending_gap) @(posedge clock);
      end
      pending_gap = 0;
      req_ch.mode          <= item.mode;
      req_ch.position_key  <= item.position_key;
      req_ch.search_depth  <= item.search_depth;
      req_ch.node_score    <= item.node_score;
      req_ch.bound_kind    <= item.bound_kind;
      req_ch.ply_from_root <= item.ply_from_root;
      req_ch.best_move_in  <= item.best_move_in;
      req_ch.window_low    <= item.window_low;
      req_ch.window_high   <= item.window_high;
      req_ch.valid         <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pred = predict_table_op(item);
      expected_rsp_q.push_back(typed ? want : pred);
      items_accepted++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left  = $urandom_range(1, 24);
         pending_gap = $urandom_range(1, 8);
      end
   endtask

   initial begin : stimulus
      req_ch.valid         <= 1'b0;
      req_ch.mode          <= '0;
      req_ch.position_key  <= '0;
      req_ch.search_depth  <= '0;
      req_ch.node_score    <= '0;
      req_ch.bound_kind    <= '0;
      req_ch.ply_from_root <= '0;
      req_ch.best_move_in  <= '0;
      req_ch.window_low    <= '0;
      req_ch.window_high   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_key[i]   = '0;
         shadow_depth[i] = '0;
         shadow_bound[i] = '0;
         shadow_move[i]  = '0;
         shadow_score[i] = 0;
      end
      key_tags[0] = '0;
      key_tags[1] = '1;
      key_tags[2] = 52'({$urandom, $urandom});
      key_tags[3] = 52'({$urandom, $urandom});
      key_slots[0] = '0;
      key_slots[1] = '1;
      for (int i = 2; i < 12; i++)
         key_slots[i] = 12'($urandom);

      // after reset, key zero hits an empty entry with an exact bound
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd0, 0, 0, stt_pkg::BOUND_EXACT, 0, 0, 0, 0),
              1'b1, RSP_EMPTY_HIT);
      add_row(req_of(stt_pkg::MODE_PROBE, KEY_ONES, 255, 0, stt_pkg::BOUND_EXACT, 255, 0,
                     0, 0), 1'b1, RSP_NONE);
      add_row(req_of(stt_pkg::MODE_NOP, KEY_ONES, 255, -1, 2'b11, 255, 65535, -1, -1),
              1'b1, RSP_NONE);
      add_row(req_of(stt_pkg::MODE_STORE, KEY_ONES, 255, 99500, stt_pkg::BOUND_EXACT, 7,
                     65535, 0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, KEY_ONES, 255, 0, stt_pkg::BOUND_EXACT, 7, 0, 0, 0));
      add_row(req_of(stt_pkg::MODE_PROBE, KEY_ONES, 0, 0, stt_pkg::BOUND_EXACT, 0, 0, 0, 0));
      // null move leaves the entry alone
      add_row(req_of(stt_pkg::MODE_STORE, 64'h0FFF, 0, 5, stt_pkg::BOUND_LOWER, 0,
                     stt_pkg::NULL_MOVE, 0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, KEY_ONES, 100, 0, stt_pkg::BOUND_EXACT, 3, 0, 0, 0));
      add_row(req_of(stt_pkg::MODE_STORE, 64'hA000_0000_0000_1000, 200, 1234,
                     stt_pkg::BOUND_EXACT, 0, 9, 0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_STORE, 64'd1, 0, -99500, stt_pkg::BOUND_UPPER, 255, 1,
                     0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd1, 0, 0, stt_pkg::BOUND_EXACT, 255, 0,
                     -524288, 0));
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd1, 0, 0, stt_pkg::BOUND_EXACT, 0, 0, 524287, 0));
      add_row(req_of(stt_pkg::MODE_STORE, 64'd2, 50, 524287, stt_pkg::BOUND_LOWER, 0,
                     16'h8000, 0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd2, 50, 0, stt_pkg::BOUND_EXACT, 0, 0, 0,
                     524287));
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd2, 50, 0, stt_pkg::BOUND_EXACT, 0, 0, 0,
                     -524288));
      // bound kind three never gives a cutoff
      add_row(req_of(stt_pkg::MODE_STORE, 64'd3, 255, -524288, 2'b11, 0, 5, 0, 0),
              1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd3, 0, 0, stt_pkg::BOUND_EXACT, 0, 0, 524287,
                     -524288));
      add_row(req_of(stt_pkg::MODE_STORE, 64'd4, 10, 100000, stt_pkg::BOUND_EXACT, 255, 4,
                     0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd4, 10, 0, stt_pkg::BOUND_EXACT, 0, 0, 0, 0));
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd4, 11, 0, stt_pkg::BOUND_EXACT, 0, 0, 0, 0));
      add_row(req_of(stt_pkg::MODE_STORE, 64'd5, 1, -100000, stt_pkg::BOUND_EXACT, 255, 6,
                     0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd5, 1, 0, stt_pkg::BOUND_EXACT, 3, 0, 0, 0));
      // edge of the mate range is not adjusted
      add_row(req_of(stt_pkg::MODE_STORE, 64'd6, 1, 99000, stt_pkg::BOUND_EXACT, 100, 7,
                     0, 0), 1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd6, 1, 0, stt_pkg::BOUND_EXACT, 100, 0, 0, 0));
      add_row(req_of(stt_pkg::MODE_CLEAR, 64'd0, 0, 0, stt_pkg::BOUND_EXACT, 0, 0, 0, 0),
              1'b1, RSP_DONE);
      add_row(req_of(stt_pkg::MODE_PROBE, KEY_ONES, 0, 0, stt_pkg::BOUND_EXACT, 0, 0, 0, 0),
              1'b1, RSP_NONE);
      // cleared entry keeps its depth and score, so key zero may cut off
      add_row(req_of(stt_pkg::MODE_PROBE, 64'd0, 100, 0, stt_pkg::BOUND_EXACT, 0, 0, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 900 && n < 1050);
         if (n == DRAIN_AT) begin
            req_ch.valid <= 1'b0;
            while (expected_rsp_q.size() != 0) @(posedge clock);
         end
         offer(random_item(), 1'b0, RSP_NONE);
      end
      req_ch.valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // receiver stalls on a rotating pattern, with one long hold-off
   initial begin : rsp_backpressure
      logic [15:0] pattern;
      bit          held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         pattern = 16'($urandom);
         if ($urandom_range(0, 3) == 0)
            pattern = '1;
         else if (pattern == '0)
            pattern = 16'h8421;
         for (int k = 0; k < 64; k++) begin
            @(posedge clock);
            if (!held && items_accepted >= HOLD_AT) begin
               held = 1'b1;
               rsp_ch.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
            end else begin
               rsp_ch.ready <= pattern[k % 16];
            end
         end
      end
   end

   always @(posedge clock) begin
      stt_pkg::rsp_payload_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response transfer with nothing outstanding");
            errors++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_ch.key_match !== want.key_match) begin
               $error("key_match: expected %0d, actual %0d", want.key_match, rsp_ch.key_match);
               errors++;
            end
            if (rsp_ch.cutoff_valid !== want.cutoff_valid) begin
               $error("cutoff_valid: expected %0d, actual %0d",
                      want.cutoff_valid, rsp_ch.cutoff_valid);
               errors++;
            end
            if (rsp_ch.cutoff_score !== want.cutoff_score) begin
               $error("cutoff_score: expected %0d, actual %0d",
                      $signed(want.cutoff_score), $signed(rsp_ch.cutoff_score));
               errors++;
            end
            if (rsp_ch.stored_move !== want.stored_move) begin
               $error("stored_move: expected %0h, actual %0h",
                      want.stored_move, rsp_ch.stored_move);
               errors++;
            end
            if (rsp_ch.op_done !== want.op_done) begin
               $error("op_done: expected %0d, actual %0d", want.op_done, rsp_ch.op_done);
               errors++;
            end
         end
      end
   end

   initial begin : run_limit
      #12_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
